/* hdl/ssge_pkg.sv */
// ----------------------------------------------------------------------------
// ssge_pkg
// Types, constants and helpers shared by the subgradient step engine.
// ----------------------------------------------------------------------------
package ssge_pkg;

    localparam int NV = 4;
    localparam int W = 32;
    localparam int BW = 33;
    localparam int PW = 65;
    localparam int WW = 72;
    localparam int NUM_W = 64;
    localparam int DEN_W = 34;

    localparam logic [1:0] CFG_DIRECTION_MODE = 2'd0;
    localparam logic [1:0] CFG_STEP_SIZE_MODE = 2'd1;
    localparam logic [1:0] CFG_TARGET_COST = 2'd2;
    localparam logic [1:0] CFG_DIMS_IN_USE = 2'd3;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;
    localparam logic DIR_CONJUGATE = 1'b0;
    localparam logic DIR_FILTER = 1'b1;

    localparam logic [1:0] SS_KNOWN = 2'd0;
    localparam logic [1:0] SS_SEMI = 2'd1;
    localparam logic [1:0] SS_UNKNOWN = 2'd2;
    localparam logic [1:0] SS_FIXED = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_USE,
        ST_DIV,
        ST_FIN
    } state_t;

    typedef enum logic [2:0] {
        OP_NP,
        OP_D,
        OP_BETA,
        OP_F09,
        OP_F01,
        OP_SS,
        OP_G,
        OP_MOVE
    } op_t;

    typedef enum logic [1:0] {
        DK_BETA,
        DK_GAMMA,
        DK_ALPHA
    } divk_t;

    typedef struct packed {
        logic                    start;
        logic signed [NUM_W-1:0] num;
        logic [DEN_W-1:0]        den;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic signed [W-1:0] q;
    } div_rsp_t;

    function automatic logic signed [W-1:0] sat32(input logic signed [WW-1:0] v);
        logic signed [WW-1:0] smax;
        logic signed [WW-1:0] smin;
        smax = WW'(32'sh7fffffff);
        smin = WW'(32'sh80000000);
        if (v > smax)
            return 32'sh7fffffff;
        else if (v < smin)
            return 32'sh80000000;
        else
            return W'(v);
    endfunction

endpackage

/* hdl/subgradient_step_engine.sv */
// ----------------------------------------------------------------------------
// subgradient_step_engine
// Conjugate-style or filtered subgradient descent step with Polyak or fixed step sizes, Q16.16.
//
//   channel | signals                                  | moves
//   in      | in_valid, in_ready, action, cost_now, vec | one load or step word
//   out     | out_valid, out_ready, next, best, ...     | one result word
//   cfg     | cfg_we, cfg_index, cfg_data              | one register write
//
// A load goes through the finish state to the output register once the slot
// is free. A step makes lane passes (multiply, merge, use) and divisions
// on the shared divider, which runs a bit-per-cycle loop.
// One word is in work at a time; a new word is taken while a result waits.
// Reset clears the point, direction, best point, step count and registers, save dims in use, set to 2.
// ----------------------------------------------------------------------------
module subgradient_step_engine
    import ssge_pkg::*;
#(
    parameter int DIM = 4,
    parameter int FRAC_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                action,
    input  logic signed [31:0]  cost_now,
    input  logic signed [31:0]  vec_0,
    input  logic signed [31:0]  vec_1,
    input  logic signed [31:0]  vec_2,
    input  logic signed [31:0]  vec_3,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  next_0,
    output logic signed [31:0]  next_1,
    output logic signed [31:0]  next_2,
    output logic signed [31:0]  next_3,
    output logic signed [31:0]  best_0,
    output logic signed [31:0]  best_1,
    output logic signed [31:0]  best_2,
    output logic signed [31:0]  best_3,
    output logic signed [31:0]  lowest_cost,
    output logic                degenerate
);

    localparam longint QONE = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [W-1:0] Q_0P9 = W'((9 * QONE + 5) / 10);
    localparam logic signed [W-1:0] Q_0P1 = W'((QONE + 5) / 10);
    localparam logic signed [W-1:0] Q_0P001 = W'((QONE + 500) / 1000);

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    divk_t  divk_reg, divk_next;

    logic                dir_reg, dir_next;
    logic [1:0]          ssm_reg, ssm_next;
    logic signed [W-1:0] tgt_reg, tgt_next;
    logic [2:0]          dims_reg, dims_next;

    logic signed [W-1:0] pos_reg [NV];
    logic signed [W-1:0] pos_next [NV];
    logic signed [W-1:0] sp_reg [NV];
    logic signed [W-1:0] sp_next [NV];
    logic signed [W-1:0] bp_reg [NV];
    logic signed [W-1:0] bp_next [NV];
    logic signed [W-1:0] bc_reg, bc_next;
    logic                bv_reg, bv_next;
    logic [W-1:0]        step_reg, step_next;

    logic signed [W-1:0] v_reg [NV];
    logic signed [W-1:0] v_next [NV];
    logic signed [W-1:0] s_reg [NV];
    logic signed [W-1:0] s_next [NV];
    logic signed [W-1:0] t_reg [NV];
    logic signed [W-1:0] t_next [NV];
    logic signed [W-1:0] cost_reg, cost_next;
    logic signed [W-1:0] np_reg, np_next;
    logic signed [W-1:0] nrm_reg, nrm_next;
    logic signed [W-1:0] beta_reg, beta_next;
    logic signed [W-1:0] gamma_reg, gamma_next;
    logic signed [W-1:0] alpha_reg, alpha_next;
    logic                dg_reg, dg_next;

    logic                ov_reg, ov_next;
    logic signed [W-1:0] on_reg [NV];
    logic signed [W-1:0] on_next [NV];
    logic signed [W-1:0] ob_reg [NV];
    logic signed [W-1:0] ob_next [NV];
    logic signed [W-1:0] olc_reg, olc_next;
    logic                odg_reg, odg_next;

    logic signed [W-1:0]  vin [NV];
    logic                 act [NV];
    logic signed [W-1:0]  la [NV];
    logic signed [BW-1:0] lb [NV];
    logic signed [PW-1:0] lp [NV];
    logic signed [W-1:0]  msum;
    logic                 accept;
    logic                 slot_free;
    logic                 beta_go;
    logic                 ss_div;
    div_req_t             dreq;
    div_rsp_t             drsp;

    function automatic logic signed [NUM_W-1:0] qnum(input logic signed [DEN_W-1:0] x);
        return NUM_W'(x) <<< FRAC_BITS;
    endfunction

    assign vin[0] = vec_0;
    assign vin[1] = vec_1;
    assign vin[2] = vec_2;
    assign vin[3] = vec_3;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept = in_valid && in_ready;
    assign slot_free = !ov_reg || out_ready;
    assign beta_go = (np_reg > 0) && (msum < 0);
    assign ss_div = (msum > 0) && (ssm_reg != SS_FIXED);

    always_comb
    begin
        for (int i = 0; i < NV; i++)
        begin
            act[i] = (i < DIM) && (int'(dims_reg) > i);
        end
    end

    // lane operands
    always_comb
    begin
        for (int i = 0; i < NV; i++)
        begin
            case (op_reg)
                OP_NP:
                begin
                    la[i] = sp_reg[i];
                    lb[i] = BW'(sp_reg[i]);
                end
                OP_D:
                begin
                    la[i] = sp_reg[i];
                    lb[i] = BW'(v_reg[i]);
                end
                OP_BETA:
                begin
                    la[i] = beta_reg;
                    lb[i] = BW'(sp_reg[i]);
                end
                OP_F09:
                begin
                    la[i] = Q_0P9;
                    lb[i] = BW'(v_reg[i]);
                end
                OP_F01:
                begin
                    la[i] = Q_0P1;
                    lb[i] = BW'(sp_reg[i]);
                end
                OP_SS:
                begin
                    la[i] = s_reg[i];
                    lb[i] = BW'(s_reg[i]);
                end
                OP_G:
                begin
                    la[i] = gamma_reg;
                    lb[i] = BW'(tgt_reg) - BW'(bc_reg);
                end
                OP_MOVE:
                begin
                    la[i] = alpha_reg;
                    lb[i] = BW'(s_reg[i]);
                end
                default:
                begin
                    la[i] = '0;
                    lb[i] = '0;
                end
            endcase
        end
    end

    for (genvar g = 0; g < NV; g++)
    begin : g_lane
        if (g < DIM)
        begin : g_on
            ssge_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
                .clk (clk),
                .en  (state_reg == ST_MUL),
                .a   (la[g]),
                .b   (lb[g]),
                .p   (lp[g])
            );
        end
        else
        begin : g_off
            assign lp[g] = '0;
        end
    end

    ssge_merge #(.DIM(DIM)) u_merge (
        .clk (clk),
        .en  (state_reg == ST_ACC),
        .p   (lp),
        .sum (msum)
    );

    ssge_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = (action == ACT_LOAD) ? ST_FIN : ST_MUL;
            end
            ST_MUL:
                state_next = ST_ACC;
            ST_ACC:
                state_next = ST_USE;
            ST_USE:
            begin
                case (op_reg)
                    OP_D:
                        state_next = beta_go ? ST_DIV : ST_MUL;
                    OP_SS:
                        state_next = ss_div ? ST_DIV : ST_MUL;
                    OP_G:
                        state_next = ST_DIV;
                    OP_MOVE:
                        state_next = ST_FIN;
                    default:
                        state_next = ST_MUL;
                endcase
            end
            ST_DIV:
            begin
                if (drsp.done)
                    state_next = (divk_reg == DK_GAMMA && ssm_reg == SS_UNKNOWN) ?
                                 ST_DIV : ST_MUL;
            end
            ST_FIN:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        op_next = op_reg;
        divk_next = divk_reg;
        dir_next = dir_reg;
        ssm_next = ssm_reg;
        tgt_next = tgt_reg;
        dims_next = dims_reg;
        pos_next = pos_reg;
        sp_next = sp_reg;
        bp_next = bp_reg;
        bc_next = bc_reg;
        bv_next = bv_reg;
        step_next = step_reg;
        v_next = v_reg;
        s_next = s_reg;
        t_next = t_reg;
        cost_next = cost_reg;
        np_next = np_reg;
        nrm_next = nrm_reg;
        beta_next = beta_reg;
        gamma_next = gamma_reg;
        alpha_next = alpha_reg;
        dg_next = dg_reg;
        ov_next = ov_reg && !out_ready;
        on_next = on_reg;
        ob_next = ob_reg;
        olc_next = olc_reg;
        odg_next = odg_reg;
        dreq.start = 1'b0;
        dreq.num = '0;
        dreq.den = '0;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_DIRECTION_MODE:
                    dir_next = cfg_data[0];
                CFG_STEP_SIZE_MODE:
                    ssm_next = cfg_data[1:0];
                CFG_TARGET_COST:
                    tgt_next = signed'(cfg_data);
                CFG_DIMS_IN_USE:
                    dims_next = cfg_data[2:0];
                default:
                    dims_next = dims_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    dg_next = 1'b0;
                    cost_next = cost_now;
                    for (int i = 0; i < NV; i++)
                    begin
                        v_next[i] = act[i] ? vin[i] : '0;
                    end
                    if (action == ACT_LOAD)
                    begin
                        for (int i = 0; i < NV; i++)
                        begin
                            pos_next[i] = act[i] ? vin[i] : '0;
                            bp_next[i] = act[i] ? vin[i] : '0;
                            sp_next[i] = '0;
                        end
                        bc_next = '0;
                        bv_next = 1'b0;
                        step_next = '0;
                    end
                    else
                    begin
                        for (int i = 0; i < NV; i++)
                        begin
                            pos_next[i] = act[i] ? pos_reg[i] : '0;
                            sp_next[i] = act[i] ? sp_reg[i] : '0;
                        end
                        if (!bv_reg || cost_now < bc_reg)
                        begin
                            bc_next = cost_now;
                            bv_next = 1'b1;
                            for (int i = 0; i < NV; i++)
                            begin
                                bp_next[i] = act[i] ? pos_reg[i] : '0;
                            end
                        end
                        op_next = (dir_reg == DIR_CONJUGATE) ? OP_NP : OP_F09;
                    end
                end
            end
            ST_USE:
            begin
                case (op_reg)
                    OP_NP:
                    begin
                        np_next = msum;
                        op_next = OP_D;
                    end
                    OP_D:
                    begin
                        beta_next = '0;
                        op_next = OP_BETA;
                        if (beta_go)
                        begin
                            dreq.start = 1'b1;
                            dreq.num = -((NUM_W'(msum) <<< 1) + NUM_W'(msum)) <<< FRAC_BITS;
                            dreq.den = DEN_W'(np_reg) << 1;
                            divk_next = DK_BETA;
                        end
                    end
                    OP_BETA:
                    begin
                        for (int i = 0; i < NV; i++)
                        begin
                            s_next[i] = sat32(WW'(v_reg[i]) + WW'(lp[i]));
                        end
                        op_next = OP_SS;
                    end
                    OP_F09:
                    begin
                        for (int i = 0; i < NV; i++)
                        begin
                            t_next[i] = W'(lp[i]);
                        end
                        op_next = OP_F01;
                    end
                    OP_F01:
                    begin
                        for (int i = 0; i < NV; i++)
                        begin
                            s_next[i] = sat32(WW'(t_reg[i]) + WW'(lp[i]));
                        end
                        op_next = OP_SS;
                    end
                    OP_SS:
                    begin
                        nrm_next = msum;
                        op_next = OP_MOVE;
                        if (msum <= 0)
                        begin
                            dg_next = 1'b1;
                            alpha_next = '0;
                        end
                        else if (ssm_reg == SS_FIXED)
                        begin
                            alpha_next = Q_0P001;
                        end
                        else if (ssm_reg == SS_KNOWN)
                        begin
                            dreq.start = 1'b1;
                            dreq.num = qnum(DEN_W'(cost_reg) - DEN_W'(tgt_reg));
                            dreq.den = DEN_W'(msum);
                            divk_next = DK_ALPHA;
                        end
                        else
                        begin
                            dreq.start = 1'b1;
                            dreq.num = NUM_W'(10) <<< FRAC_BITS;
                            dreq.den = DEN_W'(step_reg) + DEN_W'(10);
                            divk_next = DK_GAMMA;
                        end
                    end
                    OP_G:
                    begin
                        dreq.start = 1'b1;
                        dreq.num = qnum(DEN_W'(cost_reg) -
                                        DEN_W'(sat32(WW'(bc_reg) + WW'(lp[0]))));
                        dreq.den = DEN_W'(nrm_reg);
                        divk_next = DK_ALPHA;
                    end
                    OP_MOVE:
                    begin
                        for (int i = 0; i < NV; i++)
                        begin
                            pos_next[i] = sat32(WW'(pos_reg[i]) - WW'(lp[i]));
                            sp_next[i] = s_reg[i];
                        end
                        if (step_reg != '1)
                            step_next = step_reg + W'(1);
                    end
                    default:
                        op_next = op_reg;
                endcase
            end
            ST_DIV:
            begin
                if (drsp.done)
                begin
                    case (divk_reg)
                        DK_BETA:
                        begin
                            beta_next = drsp.q;
                            op_next = OP_BETA;
                        end
                        DK_GAMMA:
                        begin
                            gamma_next = drsp.q;
                            if (ssm_reg == SS_UNKNOWN)
                            begin
                                dreq.start = 1'b1;
                                dreq.num = qnum(DEN_W'(cost_reg) - DEN_W'(bc_reg) +
                                                DEN_W'(drsp.q));
                                dreq.den = DEN_W'(nrm_reg);
                                divk_next = DK_ALPHA;
                            end
                            else
                            begin
                                op_next = OP_G;
                            end
                        end
                        default:
                        begin
                            alpha_next = drsp.q;
                            op_next = OP_MOVE;
                        end
                    endcase
                end
            end
            ST_FIN:
            begin
                if (slot_free)
                begin
                    ov_next = 1'b1;
                    for (int i = 0; i < NV; i++)
                    begin
                        on_next[i] = act[i] ? pos_reg[i] : '0;
                        ob_next[i] = act[i] ? bp_reg[i] : '0;
                    end
                    olc_next = bc_reg;
                    odg_next = dg_reg;
                end
            end
            default:
                op_next = op_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg <= OP_NP;
            divk_reg <= DK_BETA;
            dir_reg <= 1'b0;
            ssm_reg <= SS_KNOWN;
            tgt_reg <= '0;
            dims_reg <= 3'd2;
            for (int i = 0; i < NV; i++)
            begin
                pos_reg[i] <= '0;
                sp_reg[i] <= '0;
                bp_reg[i] <= '0;
            end
            bc_reg <= '0;
            bv_reg <= 1'b0;
            step_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg <= op_next;
            divk_reg <= divk_next;
            dir_reg <= dir_next;
            ssm_reg <= ssm_next;
            tgt_reg <= tgt_next;
            dims_reg <= dims_next;
            pos_reg <= pos_next;
            sp_reg <= sp_next;
            bp_reg <= bp_next;
            bc_reg <= bc_next;
            bv_reg <= bv_next;
            step_reg <= step_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        s_reg <= s_next;
        t_reg <= t_next;
        cost_reg <= cost_next;
        np_reg <= np_next;
        nrm_reg <= nrm_next;
        beta_reg <= beta_next;
        gamma_reg <= gamma_next;
        alpha_reg <= alpha_next;
        dg_reg <= dg_next;
        on_reg <= on_next;
        ob_reg <= ob_next;
        olc_reg <= olc_next;
        odg_reg <= odg_next;
    end

    assign out_valid = ov_reg;
    assign next_0 = on_reg[0];
    assign next_1 = on_reg[1];
    assign next_2 = on_reg[2];
    assign next_3 = on_reg[3];
    assign best_0 = ob_reg[0];
    assign best_1 = ob_reg[1];
    assign best_2 = ob_reg[2];
    assign best_3 = ob_reg[3];
    assign lowest_cost = olc_reg;
    assign degenerate = odg_reg;

endmodule

/* hdl/ssge_lane.sv */
// ----------------------------------------------------------------------------
// ssge_lane
// One element lane: fixed-point product with floor shift, registered.
// ----------------------------------------------------------------------------
module ssge_lane
    import ssge_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [W-1:0]  a,
    input  logic signed [BW-1:0] b,
    output logic signed [PW-1:0] p
);

    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] p_reg;

    assign prod = PW'(a) * PW'(b);
    assign p = p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= prod >>> FRAC_BITS;
        end
    end

endmodule

/* hdl/ssge_merge.sv */
// ----------------------------------------------------------------------------
// ssge_merge
// Sums the lane products and saturates to 32 bits, registered.
// ----------------------------------------------------------------------------
module ssge_merge
    import ssge_pkg::*;
#(
    parameter int DIM = 4
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [PW-1:0] p [NV],
    output logic signed [W-1:0]  sum
);

    logic signed [WW-1:0] acc;
    logic signed [W-1:0]  sum_reg;

    always_comb
    begin
        acc = '0;
        for (int i = 0; i < DIM; i++)
        begin
            acc = acc + WW'(p[i]);
        end
    end

    assign sum = sum_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg <= sat32(acc);
        end
    end

endmodule

/* hdl/ssge_div.sv */
// ----------------------------------------------------------------------------
// ssge_div
// Restoring divider, one quotient bit per cycle, truncating and saturating.
// ----------------------------------------------------------------------------
module ssge_div
    import ssge_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                busy_reg;
    logic [5:0]          cnt_reg;
    logic                done_reg;
    logic [NUM_W-1:0]    n_reg;
    logic [NUM_W-1:0]    q_reg;
    logic [DEN_W-1:0]    rem_reg;
    logic [DEN_W-1:0]    den_reg;
    logic                neg_reg;
    logic signed [W-1:0] res_reg;

    logic [DEN_W:0]      trial;
    logic                ge;
    logic [DEN_W-1:0]    rem_next;
    logic [NUM_W-1:0]    q_next;
    logic signed [W-1:0] res_next;
    logic                load;

    assign load = req.start && !busy_reg;
    assign trial = {rem_reg, n_reg[NUM_W-1]};
    assign ge = trial >= {1'b0, den_reg};
    assign rem_next = ge ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
    assign q_next = {q_reg[NUM_W-2:0], ge};

    always_comb
    begin
        if (!neg_reg)
            res_next = (q_next > 64'h7fffffff) ? 32'sh7fffffff : W'(q_next);
        else
            res_next = (q_next > 64'h80000000) ? 32'sh80000000 : W'(-q_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (load)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= 6'd63;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            n_reg <= req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);
            neg_reg <= req.num[NUM_W-1];
            q_reg <= '0;
            rem_reg <= '0;
            den_reg <= req.den;
        end
        else if (busy_reg)
        begin
            n_reg <= {n_reg[NUM_W-2:0], 1'b0};
            q_reg <= q_next;
            rem_reg <= rem_next;
            if (cnt_reg == 6'd0)
            begin
                res_reg <= res_next;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.q = res_reg;

endmodule

/* hdl/ssge_checker.sv */
// ----------------------------------------------------------------------------
// ssge_checker
// Port-level checks on the subgradient step engine, bound to the top level.
// ----------------------------------------------------------------------------
module ssge_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] lowest_cost,
    input logic [31:0] next_0
);

    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready
    ) else $error("input taken while a word is in work");

    a_result_from_work: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready)
    ) else $error("result word appeared without work in progress");

    a_result_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(lowest_cost) && $stable(next_0)
    ) else $error("stalled result word changed");

endmodule

bind subgradient_step_engine ssge_checker u_ssge_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .lowest_cost (lowest_cost),
    .next_0      (next_0)
);
